// ===== rtl/set_assoc_lru_cache_sim_macros.svh =====
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_sim_macros.svh
// Assertion shorthands for the cache simulator; both check at the rising
// edge of aclk and stay quiet while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef SET_ASSOC_LRU_CACHE_SIM_MACROS_SVH
`define SET_ASSOC_LRU_CACHE_SIM_MACROS_SVH

// Consequent checked in the same cycle as the antecedent
`define SALC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent
`define SALC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/salc_pkg.sv =====
// ----------------------------------------------------------------------------
// salc_pkg
// Shared widths, register indexes, sequencer states and the control and
// status bundles between the sequencer and the way unit.
// ----------------------------------------------------------------------------
package salc_pkg;

    // Fixed field widths
    localparam int ADDR_W     = 64;
    localparam int TAG_W      = 62;
    localparam int CNT_W      = 32;
    localparam int SET_BITS_W = 4;
    localparam int WAYS_W     = 4;
    localparam int OFF_W      = 6;
    localparam int CFG_DATA_W = 6;
    localparam int CFG_IDX_W  = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS_USED   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd2;

    // Sequencer states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_LOAD,
        S_SCAN,
        S_APPLY,
        S_WRITE
    } salc_state_t;

    // Sequencer to way unit
    typedef struct packed {
        logic load;        // take the row read from the tag store
        logic scan_start;  // restart the way scan
        logic scan_step;   // examine one way
        logic apply;       // update valid, tag and ranks for the access
    } salc_way_ctl_t;

    // Way unit to sequencer
    typedef struct packed {
        logic last;   // this scan step ends the search
        logic hit;    // finished scan found the tag
        logic evict;  // finished scan found no match and no free way
    } salc_way_st_t;

    // Bits of an LRU rank for a given way count
    function automatic int rank_width(input int ways);
        return (ways > 1) ? $clog2(ways) : 1;
    endfunction

endpackage

// ===== rtl/set_assoc_lru_cache_sim.sv =====
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_sim
// Tag-only set-associative cache with LRU replacement and saturating hit,
// miss and eviction totals.
// ----------------------------------------------------------------------------
// After reset the block sweeps the tag store, one set per cycle, through
// every set before s_ready first rises; configuration writes are taken
// meanwhile. A load or store word then passes through read, load, scan,
// apply and write; a modify scans and applies twice. Each scan runs the
// shared tag comparator over the ways, one per cycle, stopping at the
// first match, at most ways_used. One read and one write of the set's row
// frame each word. The result sits in an output register, so the next
// word can be accepted while it waits for m_ready.
// ----------------------------------------------------------------------------
`include "set_assoc_lru_cache_sim_macros.svh"

module set_assoc_lru_cache_sim import salc_pkg::*; #(
    parameter int MAX_SETS = 1024,
    parameter int MAX_WAYS = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    // access words
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [ADDR_W-1:0]     s_address,
    input  logic                  s_mode,
    // results
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_first_hit,
    output logic                  m_first_evicted,
    output logic                  m_second_valid,
    output logic                  m_second_hit,
    output logic [CNT_W-1:0]      m_hit_total,
    output logic [CNT_W-1:0]      m_miss_total,
    output logic [CNT_W-1:0]      m_evict_total
);

    localparam int SET_W  = $clog2(MAX_SETS);
    localparam int SB_LIM = $clog2(MAX_SETS + 1) - 1;
    localparam int SB_W   = 5;
    localparam int WCNT_W = $clog2(MAX_WAYS + 1);
    localparam int ROW_W  = MAX_WAYS * (1 + TAG_W + rank_width(MAX_WAYS));

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        return (c == '1) ? c : c + CNT_W'(1);
    endfunction

    // Sequencer and config
    salc_state_t           state_reg, state_next;
    logic [SET_W-1:0]      clr_idx_reg;
    logic [SET_BITS_W-1:0] set_bits_reg;
    logic [WAYS_W-1:0]     ways_used_reg;
    logic [OFF_W-1:0]      offset_bits_reg;

    // Current word
    logic [ADDR_W-1:0]     shifted_reg;
    logic [TAG_W-1:0]      tag_reg;
    logic                  mode_reg;
    logic                  access_no_reg;
    logic                  first_hit_reg;
    logic                  first_evict_reg;
    logic                  second_hit_reg;

    // Totals
    logic [CNT_W-1:0]      hits_reg, hits_next;
    logic [CNT_W-1:0]      misses_reg, misses_next;
    logic [CNT_W-1:0]      evictions_reg, evictions_next;

    // Output register
    logic                  m_valid_reg;
    logic                  out_hit_reg, out_evict_reg, out_second_reg, out_second_hit_reg;
    logic [CNT_W-1:0]      out_hits_reg, out_misses_reg, out_evictions_reg;

    logic [OFF_W-1:0]      off_eff;
    logic [SET_BITS_W-1:0] sb_raw;
    logic [SB_W-1:0]       sb_eff;
    logic [WAYS_W-1:0]     wu_raw;
    logic [WCNT_W-1:0]     ways_eff;
    logic [SET_W-1:0]      set_mask;
    logic [SET_W-1:0]      set_idx;

    salc_way_ctl_t         way_ctl;
    salc_way_st_t          way_st;
    logic [ROW_W-1:0]      rd_row;
    logic [ROW_W-1:0]      way_row;
    logic                  ram_wr_en;
    logic [SET_W-1:0]      ram_wr_addr;
    logic [ROW_W-1:0]      ram_wr_data;
    logic                  accept;
    logic                  out_load;

    // Effective geometry: zero reads as one; set bits and ways saturate
    assign off_eff = (offset_bits_reg == '0) ? OFF_W'(1) : offset_bits_reg;
    assign sb_raw  = (set_bits_reg == '0) ? SET_BITS_W'(1) : set_bits_reg;
    assign sb_eff  = ({1'b0, sb_raw} > SB_W'(SB_LIM)) ? SB_W'(SB_LIM) : {1'b0, sb_raw};
    assign wu_raw  = (ways_used_reg == '0) ? WAYS_W'(1) : ways_used_reg;
    assign ways_eff = ({2'b00, wu_raw} > 6'(MAX_WAYS)) ? WCNT_W'(MAX_WAYS) : WCNT_W'(wu_raw);

    // Set index from the offset-shifted address
    always_comb begin
        for (int j = 0; j < SET_W; j++) begin
            set_mask[j] = (SB_W'(j) < sb_eff);
        end
    end
    assign set_idx = shifted_reg[SET_W-1:0] & set_mask;

    assign accept = s_valid && s_ready;

    // Sequencer
    always_comb begin
        state_next = state_reg;
        way_ctl    = '0;
        s_ready    = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            S_CLEAR: begin
                if (clr_idx_reg == SET_W'(MAX_SETS - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    state_next = S_READ;
                end
            end
            S_READ: begin
                state_next = S_LOAD;
            end
            S_LOAD: begin
                way_ctl.load       = 1'b1;
                way_ctl.scan_start = 1'b1;
                state_next         = S_SCAN;
            end
            S_SCAN: begin
                way_ctl.scan_step = 1'b1;
                if (way_st.last) begin
                    state_next = S_APPLY;
                end
            end
            S_APPLY: begin
                way_ctl.apply = 1'b1;
                if (mode_reg && !access_no_reg) begin
                    way_ctl.scan_start = 1'b1;
                    state_next         = S_SCAN;
                end else begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Totals
    always_comb begin
        hits_next      = hits_reg;
        misses_next    = misses_reg;
        evictions_next = evictions_reg;
        if (state_reg == S_APPLY) begin
            if (way_st.hit) begin
                hits_next = sat_inc(hits_reg);
            end else begin
                misses_next = sat_inc(misses_reg);
            end
            if (way_st.evict) begin
                evictions_next = sat_inc(evictions_reg);
            end
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_CLEAR;
            clr_idx_reg     <= '0;
            set_bits_reg    <= SET_BITS_W'(1);
            ways_used_reg   <= WAYS_W'(1);
            offset_bits_reg <= OFF_W'(1);
            hits_reg        <= '0;
            misses_reg      <= '0;
            evictions_reg   <= '0;
            access_no_reg   <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg     <= state_next;
            hits_reg      <= hits_next;
            misses_reg    <= misses_next;
            evictions_reg <= evictions_next;
            if (state_reg == S_CLEAR) begin
                clr_idx_reg <= clr_idx_reg + SET_W'(1);
            end
            // config writes; unknown index is dropped
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_SET_BITS:    set_bits_reg    <= cfg_wr_data[SET_BITS_W-1:0];
                    CFG_WAYS_USED:   ways_used_reg   <= cfg_wr_data[WAYS_W-1:0];
                    CFG_OFFSET_BITS: offset_bits_reg <= cfg_wr_data[OFF_W-1:0];
                    default: ;
                endcase
            end
            if (accept) begin
                access_no_reg <= 1'b0;
            end else if (state_reg == S_APPLY) begin
                access_no_reg <= 1'b1;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Word payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            shifted_reg    <= s_address >> off_eff;
            mode_reg       <= s_mode;
            second_hit_reg <= 1'b0;
        end
        if (state_reg == S_READ) begin
            tag_reg <= TAG_W'(shifted_reg >> sb_eff);
        end
        if (state_reg == S_APPLY) begin
            if (!access_no_reg) begin
                first_hit_reg   <= way_st.hit;
                first_evict_reg <= way_st.evict;
            end else begin
                second_hit_reg <= way_st.hit;
            end
        end
        if (out_load) begin
            out_hit_reg        <= first_hit_reg;
            out_evict_reg      <= first_evict_reg;
            out_second_reg     <= mode_reg;
            out_second_hit_reg <= second_hit_reg;
            out_hits_reg       <= hits_reg;
            out_misses_reg     <= misses_reg;
            out_evictions_reg  <= evictions_reg;
        end
    end

    // Tag store: cleared row by row after reset, else written back per word
    assign ram_wr_en   = (state_reg == S_CLEAR) || (state_reg == S_WRITE);
    assign ram_wr_addr = (state_reg == S_CLEAR) ? clr_idx_reg : set_idx;
    assign ram_wr_data = (state_reg == S_CLEAR) ? '0 : way_row;

    salc_row_ram #(
        .MAX_SETS (MAX_SETS),
        .ROW_W    (ROW_W)
    ) u_row_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (state_reg == S_READ),
        .rd_addr (set_idx),
        .rd_data (rd_row)
    );

    salc_way_unit #(
        .MAX_WAYS (MAX_WAYS)
    ) u_way_unit (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (way_ctl),
        .ways    (ways_eff),
        .tag     (tag_reg),
        .rd_row  (rd_row),
        .wr_row  (way_row),
        .st      (way_st)
    );

    assign m_valid         = m_valid_reg;
    assign m_first_hit     = out_hit_reg;
    assign m_first_evicted = out_evict_reg;
    assign m_second_valid  = out_second_reg;
    assign m_second_hit    = out_second_hit_reg;
    assign m_hit_total     = out_hits_reg;
    assign m_miss_total    = out_misses_reg;
    assign m_evict_total   = out_evictions_reg;

    // Checks
    `SALC_ASSERT_NEXT(a_accept_reads, accept, state_reg == S_READ, "accepted word did not start a set read")
    `SALC_ASSERT_NEXT(a_hits_rise, 1'b1, hits_reg >= $past(hits_reg), "hit total went down")
    `SALC_ASSERT_NEXT(a_misses_rise, 1'b1, misses_reg >= $past(misses_reg), "miss total went down")
    `SALC_ASSERT_SAME(a_evict_is_miss, state_reg == S_APPLY && way_st.evict, !way_st.hit, "eviction on a hit")

endmodule

// ===== rtl/salc_row_ram.sv =====
// ----------------------------------------------------------------------------
// salc_row_ram
// Tag store: one row per set holding valid, tag and rank of every way.
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module salc_row_ram import salc_pkg::*; #(
    parameter int MAX_SETS = 1024,
    parameter int ROW_W    = 528,
    localparam int SET_W   = $clog2(MAX_SETS)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [SET_W-1:0] wr_addr,
    input  logic [ROW_W-1:0] wr_data,
    input  logic             rd_en,
    input  logic [SET_W-1:0] rd_addr,
    output logic [ROW_W-1:0] rd_data
);

    logic [ROW_W-1:0] mem [MAX_SETS];
    logic [ROW_W-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/salc_way_unit.sv =====
// ----------------------------------------------------------------------------
// salc_way_unit
// Working copy of one set plus the shared tag comparator. A scan looks at
// one way per cycle, tracking the first match, first free way and LRU victim;
// apply moves the touched way to rank 0, ageing newer ways, or all on a miss.
// ----------------------------------------------------------------------------
module salc_way_unit import salc_pkg::*; #(
    parameter int MAX_WAYS = 8,
    localparam int WCNT_W  = $clog2(MAX_WAYS + 1),
    localparam int ROW_W   = MAX_WAYS * (1 + TAG_W + rank_width(MAX_WAYS))
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  salc_way_ctl_t     ctl,
    input  logic [WCNT_W-1:0] ways,
    input  logic [TAG_W-1:0]  tag,
    input  logic [ROW_W-1:0]  rd_row,
    output logic [ROW_W-1:0]  wr_row,
    output salc_way_st_t      st
);

    localparam int RANK_W = rank_width(MAX_WAYS);
    localparam int LINE_W = 1 + TAG_W + RANK_W;
    localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam logic [RANK_W-1:0] RANK_TOP = RANK_W'(MAX_WAYS - 1);

    // Working row
    logic              vld_reg  [MAX_WAYS];
    logic              vld_next [MAX_WAYS];
    logic [TAG_W-1:0]  tag_reg  [MAX_WAYS];
    logic [TAG_W-1:0]  tag_next [MAX_WAYS];
    logic [RANK_W-1:0] rank_reg [MAX_WAYS];
    logic [RANK_W-1:0] rank_next[MAX_WAYS];

    // Scan state
    logic [WCNT_W-1:0] idx_reg, idx_next;
    logic              hit_found_reg, hit_found_next;
    logic [WAY_W-1:0]  hit_way_reg, hit_way_next;
    logic [RANK_W-1:0] hit_rank_reg, hit_rank_next;
    logic              inv_found_reg, inv_found_next;
    logic [WAY_W-1:0]  inv_way_reg, inv_way_next;
    logic [WAY_W-1:0]  vic_way_reg, vic_way_next;
    logic [RANK_W-1:0] best_reg, best_next;

    logic [WAY_W-1:0]  lane;
    logic              match;
    logic              last_way;
    logic [WAY_W-1:0]  sel_way;

    // Shared comparator on the way under the scan pointer
    assign lane     = idx_reg[WAY_W-1:0];
    assign match    = vld_reg[lane] && (tag_reg[lane] == tag);
    assign last_way = (idx_reg == (ways - WCNT_W'(1)));

    // Way touched by the access: hit way, else first free, else LRU victim
    assign sel_way = hit_found_reg ? hit_way_reg :
                     (inv_found_reg ? inv_way_reg : vic_way_reg);

    assign st.last  = ctl.scan_step && (match || last_way);
    assign st.hit   = hit_found_reg;
    assign st.evict = !hit_found_reg && !inv_found_reg;

    // Next state of row and scan
    always_comb begin
        for (int i = 0; i < MAX_WAYS; i++) begin
            vld_next[i]  = vld_reg[i];
            tag_next[i]  = tag_reg[i];
            rank_next[i] = rank_reg[i];
        end
        idx_next       = idx_reg;
        hit_found_next = hit_found_reg;
        hit_way_next   = hit_way_reg;
        hit_rank_next  = hit_rank_reg;
        inv_found_next = inv_found_reg;
        inv_way_next   = inv_way_reg;
        vic_way_next   = vic_way_reg;
        best_next      = best_reg;

        // Row from the tag store
        if (ctl.load) begin
            for (int i = 0; i < MAX_WAYS; i++) begin
                {vld_next[i], tag_next[i], rank_next[i]} = rd_row[i*LINE_W +: LINE_W];
            end
        end

        // LRU update over the ways in use
        if (ctl.apply) begin
            for (int i = 0; i < MAX_WAYS; i++) begin
                if (WCNT_W'(i) < ways) begin
                    if (WAY_W'(i) == sel_way) begin
                        vld_next[i]  = 1'b1;
                        rank_next[i] = '0;
                        if (!hit_found_reg) begin
                            tag_next[i] = tag;
                        end
                    end else if (vld_reg[i] && (!hit_found_reg || rank_reg[i] < hit_rank_reg)
                                 && rank_reg[i] != RANK_TOP) begin
                        rank_next[i] = rank_reg[i] + RANK_W'(1);
                    end
                end
            end
        end

        // One way per step
        if (ctl.scan_start) begin
            idx_next       = '0;
            hit_found_next = 1'b0;
            inv_found_next = 1'b0;
        end else if (ctl.scan_step) begin
            if (match) begin
                hit_found_next = 1'b1;
                hit_way_next   = lane;
                hit_rank_next  = rank_reg[lane];
            end
            if (!vld_reg[lane] && !inv_found_reg) begin
                inv_found_next = 1'b1;
                inv_way_next   = lane;
            end
            // strictly greater keeps the lowest way on a rank tie
            if (idx_reg == '0 || rank_reg[lane] > best_reg) begin
                best_next    = rank_reg[lane];
                vic_way_next = lane;
            end
            idx_next = idx_reg + WCNT_W'(1);
        end
    end

    // Row registers
    always_ff @(posedge aclk) begin
        for (int i = 0; i < MAX_WAYS; i++) begin
            vld_reg[i]  <= vld_next[i];
            tag_reg[i]  <= tag_next[i];
            rank_reg[i] <= rank_next[i];
        end
        hit_way_reg  <= hit_way_next;
        hit_rank_reg <= hit_rank_next;
        inv_way_reg  <= inv_way_next;
        vic_way_reg  <= vic_way_next;
        best_reg     <= best_next;
    end

    // Scan control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg       <= '0;
            hit_found_reg <= 1'b0;
            inv_found_reg <= 1'b0;
        end else begin
            idx_reg       <= idx_next;
            hit_found_reg <= hit_found_next;
            inv_found_reg <= inv_found_next;
        end
    end

    // Row back to the tag store
    always_comb begin
        for (int i = 0; i < MAX_WAYS; i++) begin
            wr_row[i*LINE_W +: LINE_W] = {vld_reg[i], tag_reg[i], rank_reg[i]};
        end
    end

endmodule

// ===== test/salc_checker.sv =====
// ----------------------------------------------------------------------------
// salc_checker
// Watches the configuration port and both word channels of the cache
// simulator. It keeps its own copy of the tag store, LRU ranks, totals and
// register settings, predicts the outcome of every accepted access word, and
// compares each result word field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module salc_checker import salc_pkg::*; #(
    parameter int MAX_SETS = 1024,
    parameter int MAX_WAYS = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  logic [ADDR_W-1:0]     s_address,
    input  logic                  s_mode,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  logic                  m_first_hit,
    input  logic                  m_first_evicted,
    input  logic                  m_second_valid,
    input  logic                  m_second_hit,
    input  logic [CNT_W-1:0]      m_hit_total,
    input  logic [CNT_W-1:0]      m_miss_total,
    input  logic [CNT_W-1:0]      m_evict_total,
    output int                    mismatch_count,
    output int                    pending_words
);

    localparam int LINES     = MAX_SETS * MAX_WAYS;
    localparam int RANK_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int RANK_MAX  = MAX_WAYS - 1;
    localparam int SET_LIMIT = $clog2(MAX_SETS + 1) - 1;   // floor(log2)

    typedef struct {
        logic             first_hit;
        logic             first_evicted;
        logic             second_valid;
        logic             second_hit;
        logic [CNT_W-1:0] hits;
        logic [CNT_W-1:0] misses;
        logic [CNT_W-1:0] evicts;
    } cache_outcome_t;

    // shadow of the cache state
    logic              line_ok    [LINES];
    logic [TAG_W-1:0]  line_tags  [LINES];
    logic [RANK_W-1:0] line_age   [LINES];
    logic [CNT_W-1:0]  hit_count;
    logic [CNT_W-1:0]  miss_count;
    logic [CNT_W-1:0]  evict_count;

    logic [SET_BITS_W-1:0] set_bits_reg;
    logic [WAYS_W-1:0]     ways_reg;
    logic [OFF_W-1:0]      offset_reg;

    cache_outcome_t predicted_results [$];

    function automatic logic [CNT_W-1:0] sat_bump(input logic [CNT_W-1:0] c);
        return (c == '1) ? c : c + CNT_W'(1);
    endfunction

    // make one way the most recent; other valid lines below the limit age by one
    function automatic void lru_promote(input int base, input int nways, input int way,
                                        input int limit);
        for (int i = 0; i < nways; i++) begin
            if (i != way && line_ok[base + i] && int'(line_age[base + i]) < limit &&
                int'(line_age[base + i]) < RANK_MAX)
                line_age[base + i] = line_age[base + i] + RANK_W'(1);
        end
        line_age[base + way] = '0;
    endfunction

    // one access to the cache shadow
    function automatic void cache_lookup(input logic [ADDR_W-1:0] addr,
                                         output logic hit, output logic evicted);
        int off;
        int sb;
        int nways;
        int shift;
        int base;
        int victim;
        logic [ADDR_W-1:0] set_idx;
        logic [TAG_W-1:0]  tag;

        hit     = 1'b0;
        evicted = 1'b0;
        off   = (offset_reg == '0) ? 1 : int'(offset_reg);
        sb    = (set_bits_reg == '0) ? 1 : int'(set_bits_reg);
        nways = (ways_reg == '0) ? 1 : int'(ways_reg);
        if (sb > SET_LIMIT)
            sb = SET_LIMIT;
        if (nways > MAX_WAYS)
            nways = MAX_WAYS;

        set_idx = (addr >> off) & ((64'd1 << sb) - 64'd1);
        shift   = off + sb;
        tag     = (shift >= ADDR_W) ? '0 : TAG_W'(addr >> shift);
        base    = int'(set_idx) * MAX_WAYS;

        // search: first matching way wins
        for (int i = 0; i < nways; i++) begin
            if (!hit && line_ok[base + i] && line_tags[base + i] == tag) begin
                lru_promote(base, nways, i, int'(line_age[base + i]));
                hit = 1'b1;
            end
        end
        if (hit) begin
            hit_count = sat_bump(hit_count);
            return;
        end

        miss_count = sat_bump(miss_count);
        for (int i = 0; i < nways; i++) begin
            if (!line_ok[base + i]) begin
                line_ok[base + i]   = 1'b1;
                line_tags[base + i] = tag;
                lru_promote(base, nways, i, MAX_WAYS);
                return;
            end
        end

        // set full: oldest way goes, lowest index on a tie
        victim = 0;
        for (int i = 1; i < nways; i++) begin
            if (line_age[base + i] > line_age[base + victim])
                victim = i;
        end
        line_tags[base + victim] = tag;
        lru_promote(base, nways, victim, MAX_WAYS);
        evict_count = sat_bump(evict_count);
        evicted     = 1'b1;
    endfunction

    function automatic void compare_field(input string field, input logic [CNT_W-1:0] want,
                                          input logic [CNT_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
            mismatch_count++;
        end
    endfunction

    initial begin
        mismatch_count = 0;
        pending_words  = 0;
    end

    always @(posedge aclk) begin : monitor
        cache_outcome_t want;
        logic h1;
        logic e1;
        logic h2;
        logic e2;

        if (!aresetn) begin
            for (int i = 0; i < LINES; i++) begin
                line_ok[i]   = 1'b0;
                line_tags[i] = '0;
                line_age[i]  = '0;
            end
            hit_count    = '0;
            miss_count   = '0;
            evict_count  = '0;
            set_bits_reg = SET_BITS_W'(1);
            ways_reg     = WAYS_W'(1);
            offset_reg   = OFF_W'(1);
            predicted_results.delete();
        end else begin
            // result word against the oldest prediction
            if (m_valid && m_ready) begin
                if (predicted_results.size() == 0) begin
                    $display("%0t: result word with no prediction pending", $time);
                    mismatch_count++;
                end else begin
                    want = predicted_results.pop_front();
                    compare_field("first_hit", CNT_W'(want.first_hit), CNT_W'(m_first_hit));
                    compare_field("first_evicted", CNT_W'(want.first_evicted),
                                  CNT_W'(m_first_evicted));
                    compare_field("second_valid", CNT_W'(want.second_valid),
                                  CNT_W'(m_second_valid));
                    compare_field("second_hit", CNT_W'(want.second_hit), CNT_W'(m_second_hit));
                    compare_field("hit_total", want.hits, m_hit_total);
                    compare_field("miss_total", want.misses, m_miss_total);
                    compare_field("evict_total", want.evicts, m_evict_total);
                end
            end

            // accepted access word: one or two lookups
            if (s_valid && s_ready) begin
                cache_lookup(s_address, h1, e1);
                h2 = 1'b0;
                if (s_mode)
                    cache_lookup(s_address, h2, e2);
                want.first_hit     = h1;
                want.first_evicted = e1;
                want.second_valid  = s_mode;
                want.second_hit    = h2;
                want.hits          = hit_count;
                want.misses        = miss_count;
                want.evicts        = evict_count;
                predicted_results.push_back(want);
            end

            // register writes; unknown indexes are dropped
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_SET_BITS: begin
                        set_bits_reg = cfg_wr_data[SET_BITS_W-1:0];
                    end
                    CFG_WAYS_USED: begin
                        ways_reg = cfg_wr_data[WAYS_W-1:0];
                    end
                    CFG_OFFSET_BITS: begin
                        offset_reg = cfg_wr_data[OFF_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
        pending_words = predicted_results.size();
    end

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the set-associative LRU cache simulator. A short
// directed run covers address extremes, both modes, out-of-range register
// values, tag shifts past the address width, duplicate tags after a change
// of ways and an LRU tie; random phases follow with fresh settings, address
// pools that force reuse and conflicts, random idling on both channels and
// one long result stall. Checking is done by salc_checker.
// ----------------------------------------------------------------------------
module tb_top;
    import salc_pkg::*;

    localparam int MAX_SETS       = 1024;
    localparam int MAX_WAYS       = 8;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int LONG_HOLD      = 400;
    localparam int TAIL_CYCLES    = 30;
    localparam int RANDOM_PHASES  = 12;
    localparam int PHASE_WORDS    = 40;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wr_data;
    logic                  s_valid;
    logic                  s_ready;
    logic [ADDR_W-1:0]     s_address;
    logic                  s_mode;
    logic                  m_valid;
    logic                  m_ready;
    logic                  m_first_hit;
    logic                  m_first_evicted;
    logic                  m_second_valid;
    logic                  m_second_hit;
    logic [CNT_W-1:0]      m_hit_total;
    logic [CNT_W-1:0]      m_miss_total;
    logic [CNT_W-1:0]      m_evict_total;

    int mismatch_count;
    int pending_words;
    int words_sent;
    int words_seen;
    int quiet_cycles;
    bit tx_idle;
    bit rx_idle;
    bit long_hold_req;

    set_assoc_lru_cache_sim #(
        .MAX_SETS (MAX_SETS),
        .MAX_WAYS (MAX_WAYS)
    ) dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_address       (s_address),
        .s_mode          (s_mode),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_first_hit     (m_first_hit),
        .m_first_evicted (m_first_evicted),
        .m_second_valid  (m_second_valid),
        .m_second_hit    (m_second_hit),
        .m_hit_total     (m_hit_total),
        .m_miss_total    (m_miss_total),
        .m_evict_total   (m_evict_total)
    );

    salc_checker #(
        .MAX_SETS (MAX_SETS),
        .MAX_WAYS (MAX_WAYS)
    ) checker_i (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_address       (s_address),
        .s_mode          (s_mode),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_first_hit     (m_first_hit),
        .m_first_evicted (m_first_evicted),
        .m_second_valid  (m_second_valid),
        .m_second_hit    (m_second_hit),
        .m_hit_total     (m_hit_total),
        .m_miss_total    (m_miss_total),
        .m_evict_total   (m_evict_total),
        .mismatch_count  (mismatch_count),
        .pending_words   (pending_words)
    );

    // clock
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // gap length: mostly none, some short, a few long
    function automatic int pick_gap(input bit enabled);
        int r;
        if (!enabled)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // result side: random stalls plus one long hold-off on request
    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        m_ready    = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall_left == 0 && long_hold_req) begin
                long_hold_req = 1'b0;
                stall_left    = LONG_HOLD;
            end else if (stall_left == 0) begin
                stall_left = pick_gap(rx_idle);
            end
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // result count and watchdog on handshake activity
    always @(posedge aclk) begin
        if (m_valid && m_ready)
            words_seen <= words_seen + 1;
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog, no word moved for %0d cycles", $time, quiet_cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic send_word(input logic [ADDR_W-1:0] addr, input logic mode);
        int gap;
        gap = pick_gap(tx_idle);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_address <= addr;
        s_mode    <= mode;
        do @(posedge aclk); while (!s_ready);
        words_sent++;
    endtask

    // stop offering and wait until every result word is back
    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (words_seen != words_sent)
            @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= data;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic program_cache(input logic [CFG_DATA_W-1:0] sb,
                                 input logic [CFG_DATA_W-1:0] ways,
                                 input logic [CFG_DATA_W-1:0] off);
        wait_drained();
        write_reg(CFG_SET_BITS, sb);
        write_reg(CFG_WAYS_USED, ways);
        write_reg(CFG_OFFSET_BITS, off);
    endtask

    // new settings, mostly small caches so that lines conflict
    task automatic random_setup();
        int sb;
        int ways;
        int off;
        sb   = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(0, 63);
        ways = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 8) : $urandom_range(0, 63);
        off  = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 8) : $urandom_range(0, 63);
        program_cache(CFG_DATA_W'(sb), CFG_DATA_W'(ways), CFG_DATA_W'(off));
        if ($urandom_range(0, 3) == 0)
            write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
        tx_idle = ($urandom_range(0, 3) != 0);
        rx_idle = ($urandom_range(0, 3) != 0);
    endtask

    // addresses drawn mostly from a small pool sharing the upper bits
    task automatic random_phase(input int count);
        logic [ADDR_W-1:0] pool [16];
        logic [ADDR_W-1:0] upper;
        logic [ADDR_W-1:0] mask;
        logic [ADDR_W-1:0] addr;
        int span;
        span  = $urandom_range(4, 24);
        upper = {$urandom, $urandom};
        mask  = (64'd1 << span) - 64'd1;
        foreach (pool[k])
            pool[k] = upper ^ ({$urandom, $urandom} & mask);
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 99) < 75)
                addr = pool[$urandom_range(0, 15)] ^ ADDR_W'($urandom_range(0, 3));
            else
                addr = {$urandom, $urandom};
            send_word(addr, $urandom_range(0, 1) != 0);
        end
    endtask

    initial begin
        s_valid       = 1'b0;
        s_address     = '0;
        s_mode        = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_index     = CFG_SET_BITS;
        cfg_wr_data   = '0;
        aresetn       = 1'b0;
        tx_idle       = 1'b1;
        rx_idle       = 1'b1;
        long_hold_req = 1'b0;
        words_sent    = 0;
        words_seen    = 0;
        quiet_cycles  = 0;

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset settings: fill, hit twice, other set, evict, hit again
        send_word(64'h0, 1'b0);
        send_word(64'h0, 1'b1);
        send_word('1, 1'b0);
        send_word(64'h4, 1'b0);
        send_word(64'h4, 1'b1);

        // zero register values act as one; unused index is ignored
        program_cache(6'd0, 6'd0, 6'd0);
        write_reg(CFG_UNUSED, 6'h3F);
        send_word(64'h0, 1'b1);
        send_word(64'h5555_5555_5555_5555, 1'b0);
        send_word(64'hAAAA_AAAA_AAAA_AAAA, 1'b1);

        // oversized values saturate; tag shift runs past the address
        program_cache(6'h3F, 6'h3F, 6'd63);
        send_word('1, 1'b0);
        send_word(64'h8000_0000_0000_0000, 1'b1);
        send_word(64'h0, 1'b0);
        send_word(64'h7FFF_FFFF_FFFF_FFFF, 1'b1);

        // same tag in two ways: fill way 0 with one way, way 1 with two,
        // then overwrite way 0 with the way 1 tag
        program_cache(6'd10, 6'd1, 6'd4);
        send_word(64'h5550, 1'b0);
        program_cache(6'd10, 6'd2, 6'd4);
        send_word(64'h9550, 1'b0);
        program_cache(6'd10, 6'd1, 6'd4);
        send_word(64'h9550, 1'b0);
        program_cache(6'd10, 6'd2, 6'd4);
        send_word(64'h9550, 1'b1);

        // LRU tie: both ways end up most recent, the lower way is evicted
        send_word(64'h6AA0, 1'b0);
        send_word(64'hAAA0, 1'b0);
        program_cache(6'd10, 6'd1, 6'd4);
        send_word(64'hEAA0, 1'b0);
        program_cache(6'd10, 6'd2, 6'd4);
        send_word(64'h12AA0, 1'b0);

        // random phases, one of them under a long result stall
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            random_setup();
            if (p == 4)
                long_hold_req = 1'b1;
            random_phase(PHASE_WORDS);
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && pending_words == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
